@@ hdl/sitoa_pkg.sv @@
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONVERT,
        BK_SCAN,
        BK_DIGITS
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ hdl/sitoa_fifo.sv @@
// ----------------------------------------------------------------------------
// sitoa_fifo
// Two-entry queue between the intake stage and the digit generator.
// ----------------------------------------------------------------------------
module sitoa_fifo #(
    parameter int DATA_WIDTH = 33
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_WIDTH-1:0] push_data,
    input  logic                  pop,
    output logic [DATA_WIDTH-1:0] pop_data,
    output sitoa_pkg::q_status_t  status
);

    logic [DATA_WIDTH-1:0] mem_reg [2];
    logic                  wr_ptr_reg;
    logic                  wr_ptr_next;
    logic                  rd_ptr_reg;
    logic                  rd_ptr_next;
    logic [1:0]            count_reg;
    logic [1:0]            count_next;
    logic                  do_push;
    logic                  do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/sitoa_front.sv @@
// ----------------------------------------------------------------------------
// sitoa_front
// Intake stage: accepts a transaction, splits it into sign and magnitude.
// ----------------------------------------------------------------------------
module sitoa_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        start,
    input  logic signed [31:0]          value,
    output logic                        busy,
    input  sitoa_pkg::q_status_t        q_status,
    output logic                        push,
    output logic [VALUE_WIDTH:0]        push_data
);

    logic signed [63:0]     value_ext;
    logic [VALUE_WIDTH-1:0] raw;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;

    assign value_ext = 64'(value);
    assign raw       = value_ext[VALUE_WIDTH-1:0];
    assign neg       = raw[VALUE_WIDTH-1];
    assign mag       = neg ? (~raw + VALUE_WIDTH'(1)) : raw;
    assign busy      = q_status.full;
    assign push      = start && !q_status.full;
    assign push_data = {neg, mag};

endmodule

@@ hdl/sitoa_back.sv @@
// ----------------------------------------------------------------------------
// sitoa_back
// Digit generator: shift-and-add-3 binary to BCD, then emits the text.
// ----------------------------------------------------------------------------
module sitoa_back #(
    parameter int VALUE_WIDTH = 32,
    parameter int NDIG        = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sitoa_pkg::q_status_t       q_status,
    input  logic [VALUE_WIDTH:0]       q_data,
    output logic                       pop,
    output logic                       strobe,
    output logic [7:0]                 character,
    output logic                       last
);

    localparam int IDXW = $clog2(NDIG);
    localparam int CNTW = $clog2(VALUE_WIDTH);

    sitoa_pkg::back_state_t   state_reg;
    sitoa_pkg::back_state_t   state_next;
    logic                     neg_reg;
    logic                     neg_next;
    logic [VALUE_WIDTH-1:0]   bin_reg;
    logic [VALUE_WIDTH-1:0]   bin_next;
    logic [NDIG-1:0][3:0]     bcd_reg;
    logic [NDIG-1:0][3:0]     bcd_next;
    logic [CNTW-1:0]          bit_reg;
    logic [CNTW-1:0]          bit_next;
    logic [IDXW-1:0]          idx_reg;
    logic [IDXW-1:0]          idx_next;
    logic [4*NDIG-1:0]        adj_flat;
    logic [IDXW-1:0]          lead;

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            adj_flat[4*i +: 4] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
    end

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                lead = IDXW'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        bit_next   = bit_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        strobe     = 1'b0;
        character  = sitoa_pkg::ASCII_ZERO;
        last       = 1'b0;
        case (state_reg)
            sitoa_pkg::BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    neg_next   = q_data[VALUE_WIDTH];
                    bin_next   = q_data[VALUE_WIDTH-1:0];
                    bcd_next   = '0;
                    bit_next   = CNTW'(VALUE_WIDTH - 1);
                    state_next = sitoa_pkg::BK_CONVERT;
                end
            end
            sitoa_pkg::BK_CONVERT:
            begin
                bcd_next = {adj_flat[4*NDIG-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_next = bit_reg - CNTW'(1);
                if (bit_reg == '0)
                begin
                    state_next = sitoa_pkg::BK_SCAN;
                end
            end
            sitoa_pkg::BK_SCAN:
            begin
                idx_next   = lead;
                state_next = sitoa_pkg::BK_DIGITS;
                if (neg_reg)
                begin
                    strobe    = 1'b1;
                    character = sitoa_pkg::ASCII_MINUS;
                end
            end
            sitoa_pkg::BK_DIGITS:
            begin
                strobe    = 1'b1;
                character = sitoa_pkg::ASCII_ZERO | {4'd0, bcd_reg[idx_reg]};
                last      = (idx_reg == '0);
                idx_next  = idx_reg - IDXW'(1);
                if (idx_reg == '0)
                begin
                    state_next = sitoa_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = sitoa_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sitoa_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        bit_reg <= bit_next;
        idx_reg <= idx_next;
    end

`ifndef SYNTHESIS
    a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("Last flag raised without a character strobe.");

    a_text_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("Character text interrupted before its last character.");

    a_pop_starts_convert: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == sitoa_pkg::BK_CONVERT))
        else $error("Queue pop did not start a conversion.");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("Queue popped while empty.");
`endif

endmodule

@@ hdl/signed_int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer into its decimal ASCII text, one character
// per cycle, most significant character first.
// ----------------------------------------------------------------------------
// A transaction is accepted on a rising edge with start high and busy low;
// only the low VALUE_WIDTH bits of value are converted, as two's complement.
// The text comes out on character with strobe high for one cycle each;
// last marks its final character. A negative number begins with '-', zero
// gives a single '0', and no leading zeros appear.
// An intake stage writes sign and magnitude into a two-entry queue, so up
// to two numbers wait while a third is being converted; busy is high when
// the queue is full. The digit generator pops a number, runs a one bit per
// cycle binary to BCD conversion, locates the leading digit (emitting '-'
// there when negative), then emits one digit per cycle. The generator
// converts one number at a time and pops the next only once it is idle.
// The receiver cannot stall. Reset empties the queue and idles the
// generator; nothing else needs clearing.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] value,
    output logic               strobe,
    output logic [7:0]         character,
    output logic               last
);

    localparam int NDIG = (VALUE_WIDTH * 301) / 1000 + 1;

    sitoa_pkg::q_status_t q_status;
    logic                 push;
    logic [VALUE_WIDTH:0] push_data;
    logic                 pop;
    logic [VALUE_WIDTH:0] pop_data;

    sitoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .start     (start),
        .value     (value),
        .busy      (busy),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    sitoa_fifo #(
        .DATA_WIDTH (VALUE_WIDTH + 1)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    sitoa_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NDIG        (NDIG)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (pop_data),
        .pop       (pop),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

endmodule

@@ bench/signed_int_to_decimal_ascii_tb.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Self-checking bench for the signed integer to decimal text converter.
// Numbers are sent through the start/busy handshake, and the expected
// characters are predicted as each transaction is accepted. Every strobed
// character is compared with the oldest expected one. The stimulus covers
// directed extremes, random numbers of every digit count, random idle
// bursts, a full drain pause, and a final back-to-back stretch.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;

    localparam int VALUE_WIDTH   = 32;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] value;
    logic               strobe;
    logic [7:0]         character;
    logic               last;

    text_char_t pending_text[$];
    int         error_count;
    int         stall_cycles;
    bit         idling_on;

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .value    (value),
        .strobe   (strobe),
        .character(character),
        .last     (last)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic predict_decimal_text(input logic signed [31:0] number);
        logic [63:0] width_mask;
        logic [63:0] raw;
        logic [63:0] magnitude;
        logic        negative;
        logic [7:0]  digits [0:23];
        int          count;
        text_char_t  item;
        begin
            width_mask = (64'd1 << VALUE_WIDTH) - 64'd1;
            raw        = {{32{number[31]}}, number} & width_mask;
            negative   = raw[VALUE_WIDTH-1];
            magnitude  = negative ? ((~raw + 64'd1) & width_mask) : raw;
            count      = 0;
            do
            begin
                digits[count] = sitoa_pkg::ASCII_ZERO + 8'(magnitude % 64'd10);
                magnitude     = magnitude / 64'd10;
                count++;
            end
            while (magnitude != 64'd0);
            if (negative)
            begin
                item.ch   = sitoa_pkg::ASCII_MINUS;
                item.last = 1'b0;
                pending_text.push_back(item);
            end
            for (int i = count - 1; i >= 0; i--)
            begin
                item.ch   = digits[i];
                item.last = (i == 0);
                pending_text.push_back(item);
            end
        end
    endtask

    task automatic note_mismatch(input string what);
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("MISMATCH at %0t: %s", $realtime, what);
        end
    endtask

    always @(posedge clk)
    begin : check_text
        text_char_t want;
        if (rst_n && strobe)
        begin
            if (pending_text.size() == 0)
            begin
                note_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                        character, last));
            end
            else
            begin
                want = pending_text.pop_front();
                if (character !== want.ch)
                    note_mismatch($sformatf("character expected 0x%02h actual 0x%02h",
                                            want.ch, character));
                if (last !== want.last)
                    note_mismatch($sformatf("last expected %0b actual %0b (char 0x%02h)",
                                            want.last, last, want.ch));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            if ((start && !busy) || strobe)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_number(input logic signed [31:0] number);
        begin
            start <= 1'b1;
            value <= number;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            predict_decimal_text(number);
        end
    endtask

    task automatic maybe_idle();
        begin
            if (idling_on && $urandom_range(0, 2) == 0)
            begin
                start <= 1'b0;
                value <= $urandom;
                repeat ($urandom_range(1, 9))
                    @(posedge clk);
            end
        end
    endtask

    task automatic wait_for_drain();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pending_text.size() != 0)
                @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] random_number();
        int          digit_count;
        longint      lo;
        longint      hi;
        longint      magnitude;
        begin
            if ($urandom_range(0, 3) == 0)
                return $urandom;
            digit_count = $urandom_range(1, 10);
            lo = 1;
            repeat (digit_count - 1)
                lo = lo * 10;
            hi = lo * 10 - 1;
            if (digit_count == 1)
                lo = 0;
            if (hi > 64'sd2147483648)
                hi = 64'sd2147483648;
            magnitude = $urandom_range(int'(hi), int'(lo));
            if ($urandom_range(0, 1) == 1)
                return 32'(-magnitude);
            if (magnitude > 64'sd2147483647)
                magnitude = 64'sd2147483647;
            return 32'(magnitude);
        end
    endfunction

    task automatic test_directed_values();
        logic signed [31:0] corner [$];
        begin
            corner = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
                       32'sd99, 32'sd100, -32'sd100, 32'sd2147483647,
                       32'h8000_0000, -32'sd2147483647, 32'sd1000000000,
                       -32'sd1000000000, 32'sd999999999, 32'h5555_5555,
                       32'hAAAA_AAAA, 32'sd123456789, -32'sd123456789};
            foreach (corner[i])
            begin
                send_number(corner[i]);
                maybe_idle();
            end
        end
    endtask

    task automatic test_random_values();
        begin
            repeat (30)
            begin
                send_number(random_number());
                maybe_idle();
            end
            wait_for_drain();
            repeat (30)
            begin
                send_number(random_number());
                maybe_idle();
            end
        end
    endtask

    task automatic test_back_to_back();
        begin
            idling_on = 1'b0;
            repeat (30)
                send_number(random_number());
            start <= 1'b0;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        value        = '0;
        error_count  = 0;
        idling_on    = 1'b1;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_values();
        test_random_values();
        test_back_to_back();

        wait_for_drain();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (pending_text.size() != 0)
            note_mismatch($sformatf("%0d characters never arrived", pending_text.size()));

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ signed_int_to_decimal_ascii.f @@
hdl/sitoa_pkg.sv
hdl/sitoa_fifo.sv
hdl/sitoa_front.sv
hdl/sitoa_back.sv
hdl/signed_int_to_decimal_ascii.sv
bench/signed_int_to_decimal_ascii_tb.sv
